@@ rtl/core/rfu_pkg.sv @@
// rfu_pkg: shared constants, pipeline payload struct and rounding helpers
// for the refraction/Fresnel unit. No dependencies.
package rfu_pkg;

	localparam int FRAC    = 14;
	localparam int QFRAC   = FRAC - 2;
	localparam int ONE     = 1 << FRAC;
	localparam int HALF_F  = 1 << (FRAC - 1);
	localparam int ONE_Q   = 1 << QFRAC;
	localparam int HALF_Q  = 1 << (QFRAC - 1);
	localparam int ONE_SQ  = 1 << (2 * FRAC);
	localparam int TIR_LIM = 1 << (FRAC + QFRAC);

	// square root unit: 30-bit radicand, 15-bit root, one bit per stage
	localparam int SQ_STEPS = 15;
	localparam int RAD_W    = 2 * SQ_STEPS;
	localparam int REM_W    = SQ_STEPS + 4;

	// divider: quotient never exceeds one, so 15 quotient bits
	localparam int DV_STEPS = 15;
	localparam int DVS_W    = 31;
	localparam int DVD_W    = DVS_W + FRAC + 1;

	typedef struct packed {
		logic               mode;
		logic [15:0]        q;
		logic signed [16:0] nx;
		logic signed [16:0] ny;
		logic signed [16:0] nz;
		logic signed [15:0] dx;
		logic signed [15:0] dy;
		logic signed [15:0] dz;
		logic [14:0]        cos_t;
		logic signed [21:0] ox;
		logic signed [21:0] oy;
		logic signed [21:0] oz;
		logic               tir;
		logic [14:0]        cos_i;
		logic signed [15:0] rx;
		logic signed [15:0] ry;
		logic signed [15:0] rz;
		logic [14:0]        om;
		logic               zero_a;
		logic               zero_b;
		logic [14:0]        ra;
		logic [14:0]        rb;
	} pipe_t;

	// right shift, rounding half away from zero
	function automatic logic signed [47:0] rnd_s(input logic signed [47:0] x,
			input logic [4:0] s);
		logic signed [47:0] h;
		h = 48'sd1 <<< (s - 5'd1);
		if (x >= 0) begin
			return (x + h) >>> s;
		end else begin
			return -((-x + h) >>> s);
		end
	endfunction

	// unsigned round-to-nearest shift by FRAC
	function automatic logic [31:0] rnd_u(input logic [31:0] x);
		return (x + 32'(HALF_F)) >> FRAC;
	endfunction

endpackage

@@ rtl/core/rfu_sqrt.sv @@
// rfu_sqrt: pipelined integer square root (floor), one root bit per stage.
// Carries an rfu_pkg::pipe_t payload alongside. Depends on rfu_pkg.
module rfu_sqrt (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_vld,
	input  rfu_pkg::pipe_t             in_pl,
	input  logic [rfu_pkg::RAD_W-1:0]  in_rad,
	output logic                       out_vld,
	output rfu_pkg::pipe_t             out_pl,
	output logic [rfu_pkg::SQ_STEPS-1:0] out_root
);

	logic                              vld_s  [rfu_pkg::SQ_STEPS];
	rfu_pkg::pipe_t                    pl_s   [rfu_pkg::SQ_STEPS];
	logic [rfu_pkg::RAD_W-1:0]         rad_s  [rfu_pkg::SQ_STEPS];
	logic [rfu_pkg::REM_W-1:0]         rem_s  [rfu_pkg::SQ_STEPS];
	logic [rfu_pkg::SQ_STEPS-1:0]      root_s [rfu_pkg::SQ_STEPS];

	logic                              vld_p  [rfu_pkg::SQ_STEPS];
	rfu_pkg::pipe_t                    pl_p   [rfu_pkg::SQ_STEPS];
	logic [rfu_pkg::RAD_W-1:0]         rad_p  [rfu_pkg::SQ_STEPS];
	logic [rfu_pkg::REM_W-1:0]         rem_p  [rfu_pkg::SQ_STEPS];
	logic [rfu_pkg::SQ_STEPS-1:0]      root_p [rfu_pkg::SQ_STEPS];

	always_comb begin
		vld_p[0]  = in_vld;
		pl_p[0]   = in_pl;
		rad_p[0]  = in_rad;
		rem_p[0]  = '0;
		root_p[0] = '0;
		for (int i = 1; i < rfu_pkg::SQ_STEPS; i++) begin
			vld_p[i]  = vld_s[i-1];
			pl_p[i]   = pl_s[i-1];
			rad_p[i]  = rad_s[i-1];
			rem_p[i]  = rem_s[i-1];
			root_p[i] = root_s[i-1];
		end
	end

	for (genvar g = 0; g < rfu_pkg::SQ_STEPS; g++) begin : g_step
		logic [rfu_pkg::REM_W-1:0] rem_sh;
		logic [rfu_pkg::REM_W-1:0] trial;
		logic                      ge;

		always_comb begin
			rem_sh = {rem_p[g][rfu_pkg::REM_W-3:0],
				rad_p[g][2*(rfu_pkg::SQ_STEPS-1-g)+1 -: 2]};
			trial  = rfu_pkg::REM_W'({root_p[g], 2'b01});
			ge     = (rem_sh >= trial);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g] <= 1'b0;
			end else begin
				vld_s[g] <= vld_p[g];
			end
		end

		always_ff @(posedge clk) begin
			pl_s[g]   <= pl_p[g];
			rad_s[g]  <= rad_p[g];
			rem_s[g]  <= ge ? (rem_sh - trial) : rem_sh;
			root_s[g] <= {root_p[g][rfu_pkg::SQ_STEPS-2:0], ge};
		end
	end

	assign out_vld  = vld_s[rfu_pkg::SQ_STEPS-1];
	assign out_pl   = pl_s[rfu_pkg::SQ_STEPS-1];
	assign out_root = root_s[rfu_pkg::SQ_STEPS-1];

endmodule

@@ rtl/core/rfu_div.sv @@
// rfu_div: two-lane pipelined restoring divider, one quotient bit per stage.
// Quotients are known to fit DV_STEPS bits. Depends on rfu_pkg.
module rfu_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_vld,
	input  rfu_pkg::pipe_t               in_pl,
	input  logic [rfu_pkg::DVD_W-1:0]    dvd_a,
	input  logic [rfu_pkg::DVS_W-1:0]    dvs_a,
	input  logic [rfu_pkg::DVD_W-1:0]    dvd_b,
	input  logic [rfu_pkg::DVS_W-1:0]    dvs_b,
	output logic                         out_vld,
	output rfu_pkg::pipe_t               out_pl,
	output logic [rfu_pkg::DV_STEPS-1:0] quo_a,
	output logic [rfu_pkg::DV_STEPS-1:0] quo_b
);

	logic                         vld_s  [rfu_pkg::DV_STEPS];
	rfu_pkg::pipe_t               pl_s   [rfu_pkg::DV_STEPS];
	logic [rfu_pkg::DVD_W-1:0]    rema_s [rfu_pkg::DV_STEPS];
	logic [rfu_pkg::DVD_W-1:0]    remb_s [rfu_pkg::DV_STEPS];
	logic [rfu_pkg::DVS_W-1:0]    dvsa_s [rfu_pkg::DV_STEPS];
	logic [rfu_pkg::DVS_W-1:0]    dvsb_s [rfu_pkg::DV_STEPS];
	logic [rfu_pkg::DV_STEPS-1:0] quoa_s [rfu_pkg::DV_STEPS];
	logic [rfu_pkg::DV_STEPS-1:0] quob_s [rfu_pkg::DV_STEPS];

	logic                         vld_p  [rfu_pkg::DV_STEPS];
	rfu_pkg::pipe_t               pl_p   [rfu_pkg::DV_STEPS];
	logic [rfu_pkg::DVD_W-1:0]    rema_p [rfu_pkg::DV_STEPS];
	logic [rfu_pkg::DVD_W-1:0]    remb_p [rfu_pkg::DV_STEPS];
	logic [rfu_pkg::DVS_W-1:0]    dvsa_p [rfu_pkg::DV_STEPS];
	logic [rfu_pkg::DVS_W-1:0]    dvsb_p [rfu_pkg::DV_STEPS];
	logic [rfu_pkg::DV_STEPS-1:0] quoa_p [rfu_pkg::DV_STEPS];
	logic [rfu_pkg::DV_STEPS-1:0] quob_p [rfu_pkg::DV_STEPS];

	always_comb begin
		vld_p[0]  = in_vld;
		pl_p[0]   = in_pl;
		rema_p[0] = dvd_a;
		remb_p[0] = dvd_b;
		dvsa_p[0] = dvs_a;
		dvsb_p[0] = dvs_b;
		quoa_p[0] = '0;
		quob_p[0] = '0;
		for (int i = 1; i < rfu_pkg::DV_STEPS; i++) begin
			vld_p[i]  = vld_s[i-1];
			pl_p[i]   = pl_s[i-1];
			rema_p[i] = rema_s[i-1];
			remb_p[i] = remb_s[i-1];
			dvsa_p[i] = dvsa_s[i-1];
			dvsb_p[i] = dvsb_s[i-1];
			quoa_p[i] = quoa_s[i-1];
			quob_p[i] = quob_s[i-1];
		end
	end

	for (genvar g = 0; g < rfu_pkg::DV_STEPS; g++) begin : g_step
		logic [rfu_pkg::DVD_W-1:0] sub_a;
		logic [rfu_pkg::DVD_W-1:0] sub_b;
		logic                      ge_a;
		logic                      ge_b;

		always_comb begin
			sub_a = rfu_pkg::DVD_W'(dvsa_p[g]) << (rfu_pkg::DV_STEPS - 1 - g);
			sub_b = rfu_pkg::DVD_W'(dvsb_p[g]) << (rfu_pkg::DV_STEPS - 1 - g);
			ge_a  = (rema_p[g] >= sub_a);
			ge_b  = (remb_p[g] >= sub_b);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g] <= 1'b0;
			end else begin
				vld_s[g] <= vld_p[g];
			end
		end

		always_ff @(posedge clk) begin
			pl_s[g]   <= pl_p[g];
			dvsa_s[g] <= dvsa_p[g];
			dvsb_s[g] <= dvsb_p[g];
			rema_s[g] <= ge_a ? (rema_p[g] - sub_a) : rema_p[g];
			remb_s[g] <= ge_b ? (remb_p[g] - sub_b) : remb_p[g];
			quoa_s[g] <= {quoa_p[g][rfu_pkg::DV_STEPS-2:0], ge_a};
			quob_s[g] <= {quob_p[g][rfu_pkg::DV_STEPS-2:0], ge_b};
		end
	end

	assign out_vld = vld_s[rfu_pkg::DV_STEPS-1];
	assign out_pl  = pl_s[rfu_pkg::DV_STEPS-1];
	assign quo_a   = quoa_s[rfu_pkg::DV_STEPS-1];
	assign quo_b   = quob_s[rfu_pkg::DV_STEPS-1];

endmodule

@@ rtl/core/refraction_fresnel_unit.sv @@
// refraction_fresnel_unit: top level, Snell refraction with Schlick or Fresnel
// reflectance. Depends on rfu_pkg, rfu_sqrt, rfu_div.

// Fully pipelined: one request is taken every clock cycle and busy is always
// low. Each request produces exactly one result, shown for one cycle with done
// high; results leave in request order and the receiver cannot hold them off,
// so it must take every done cycle. Latency is set by the two 15-stage
// square-root units (sin_t, cos_i) and the 15-stage two-lane divider for the
// reflectance ratios, plus 18 arithmetic stages around them. Numbers are Q2.14
// (index quotient Q4.12). The reflectance mode register (cfg_we/cfg_wdata,
// 0 = Schlick, 1 = mean of Fresnel s and p) is sampled when a request enters,
// so change it only when the pipe is empty. On total internal reflection the
// direction is zero and the coefficient one.
module refraction_fresnel_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [15:0]        index_quotient,
	input  logic signed [15:0] normal_x,
	input  logic signed [15:0] normal_y,
	input  logic signed [15:0] normal_z,
	input  logic signed [15:0] dir_x,
	input  logic signed [15:0] dir_y,
	input  logic signed [15:0] dir_z,
	input  logic               cfg_we,
	input  logic               cfg_wdata,
	output logic               done,
	output logic signed [15:0] refracted_x,
	output logic signed [15:0] refracted_y,
	output logic signed [15:0] refracted_z,
	output logic [14:0]        reflect_coeff,
	output logic               total_reflection
);

	// clamp a rounded direction sum to 16 bits
	function automatic logic signed [15:0] sat16(input logic signed [22:0] v);
		if (v > 23'sd32767) begin
			return 16'sh7fff;
		end else if (v < -23'sd32768) begin
			return 16'sh8000;
		end else begin
			return v[15:0];
		end
	endfunction

	logic mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
		end else if (cfg_we) begin
			mode_q <= cfg_wdata;
		end
	end

	assign busy = 1'b0;

	// valid bits
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic vld_a, vld_m1, vld_m2, vld_m3, vld_c;
	logic vld_b1, vld_b2, vld_b3, vld_d;
	logic vld_f1, vld_f2, vld_f3, vld_f4, vld_f5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0; vld_s2 <= 1'b0; vld_s3 <= 1'b0;
			vld_s4 <= 1'b0; vld_s5 <= 1'b0; vld_s6 <= 1'b0;
			vld_m1 <= 1'b0; vld_m2 <= 1'b0; vld_m3 <= 1'b0;
			vld_b1 <= 1'b0; vld_b2 <= 1'b0; vld_b3 <= 1'b0;
			vld_f1 <= 1'b0; vld_f2 <= 1'b0; vld_f3 <= 1'b0;
			vld_f4 <= 1'b0; vld_f5 <= 1'b0; done   <= 1'b0;
		end else begin
			vld_s1 <= start & ~busy;
			vld_s2 <= vld_s1; vld_s3 <= vld_s2; vld_s4 <= vld_s3;
			vld_s5 <= vld_s4; vld_s6 <= vld_s5;
			vld_m1 <= vld_a;  vld_m2 <= vld_m1; vld_m3 <= vld_m2;
			vld_b1 <= vld_c;  vld_b2 <= vld_b1; vld_b3 <= vld_b2;
			vld_f1 <= vld_d;  vld_f2 <= vld_f1; vld_f3 <= vld_f2;
			vld_f4 <= vld_f3; vld_f5 <= vld_f4; done   <= vld_f5;
		end
	end

	// ---------------- front: dot product, cos_t, orthogonal part ----------
	rfu_pkg::pipe_t pl_in, pl_s1, pl_s2, pl_s3, pl_s4, pl_s5, pl_s6;
	logic signed [31:0] pdx_s1, pdy_s1, pdz_s1;

	always_comb begin
		pl_in      = '0;
		pl_in.mode = mode_q;
		pl_in.q    = index_quotient;
		pl_in.nx   = 17'(normal_x);
		pl_in.ny   = 17'(normal_y);
		pl_in.nz   = 17'(normal_z);
		pl_in.dx   = dir_x;
		pl_in.dy   = dir_y;
		pl_in.dz   = dir_z;
	end

	// s1: component products
	always_ff @(posedge clk) begin
		pl_s1  <= pl_in;
		pdx_s1 <= normal_x * dir_x;
		pdy_s1 <= normal_y * dir_y;
		pdz_s1 <= normal_z * dir_z;
	end

	// s2: sum, orient normal along the ray, cos_t clamped to one
	logic signed [33:0] dot_c, adot_c;
	logic        [33:0] ct_c;
	logic               flip_c;
	rfu_pkg::pipe_t     pl2_c;

	always_comb begin
		dot_c  = 34'(pdx_s1) + 34'(pdy_s1) + 34'(pdz_s1);
		flip_c = (dot_c <= 0);
		adot_c = flip_c ? -dot_c : dot_c;
		ct_c   = (34'(adot_c) + 34'(rfu_pkg::HALF_F)) >> rfu_pkg::FRAC;
		pl2_c       = pl_s1;
		pl2_c.nx    = flip_c ? -pl_s1.nx : pl_s1.nx;
		pl2_c.ny    = flip_c ? -pl_s1.ny : pl_s1.ny;
		pl2_c.nz    = flip_c ? -pl_s1.nz : pl_s1.nz;
		pl2_c.cos_t = (ct_c > 34'(rfu_pkg::ONE)) ? 15'(rfu_pkg::ONE) : ct_c[14:0];
	end

	always_ff @(posedge clk) begin
		pl_s2 <= pl2_c;
	end

	// s3: radicand 1 - cos_t^2, n*cos_t
	logic [rfu_pkg::RAD_W-1:0] cc_c;
	logic [rfu_pkg::RAD_W-1:0] rad_s3, rad_s4, rad_s5, rad_s6;
	logic signed [32:0] ncx_s3, ncy_s3, ncz_s3;

	assign cc_c = pl_s2.cos_t * pl_s2.cos_t;

	always_ff @(posedge clk) begin
		pl_s3  <= pl_s2;
		rad_s3 <= rfu_pkg::RAD_W'(rfu_pkg::ONE_SQ) - cc_c;
		ncx_s3 <= pl_s2.nx * $signed({1'b0, pl_s2.cos_t});
		ncy_s3 <= pl_s2.ny * $signed({1'b0, pl_s2.cos_t});
		ncz_s3 <= pl_s2.nz * $signed({1'b0, pl_s2.cos_t});
	end

	// s4: tangential part d - n*cos_t
	logic signed [17:0] tx_s4, ty_s4, tz_s4;

	always_ff @(posedge clk) begin
		pl_s4  <= pl_s3;
		rad_s4 <= rad_s3;
		tx_s4  <= 18'(pl_s3.dx) - 18'(rfu_pkg::rnd_s(48'(ncx_s3), 5'(rfu_pkg::FRAC)));
		ty_s4  <= 18'(pl_s3.dy) - 18'(rfu_pkg::rnd_s(48'(ncy_s3), 5'(rfu_pkg::FRAC)));
		tz_s4  <= 18'(pl_s3.dz) - 18'(rfu_pkg::rnd_s(48'(ncz_s3), 5'(rfu_pkg::FRAC)));
	end

	// s5: scale by q
	logic signed [34:0] tqx_s5, tqy_s5, tqz_s5;

	always_ff @(posedge clk) begin
		pl_s5  <= pl_s4;
		rad_s5 <= rad_s4;
		tqx_s5 <= tx_s4 * $signed({1'b0, pl_s4.q});
		tqy_s5 <= ty_s4 * $signed({1'b0, pl_s4.q});
		tqz_s5 <= tz_s4 * $signed({1'b0, pl_s4.q});
	end

	// s6: round back to Q2.14
	rfu_pkg::pipe_t pl6_c;

	always_comb begin
		pl6_c    = pl_s5;
		pl6_c.ox = 22'(rfu_pkg::rnd_s(48'(tqx_s5), 5'(rfu_pkg::QFRAC)));
		pl6_c.oy = 22'(rfu_pkg::rnd_s(48'(tqy_s5), 5'(rfu_pkg::QFRAC)));
		pl6_c.oz = 22'(rfu_pkg::rnd_s(48'(tqz_s5), 5'(rfu_pkg::QFRAC)));
	end

	always_ff @(posedge clk) begin
		pl_s6  <= pl6_c;
		rad_s6 <= rad_s5;
	end

	// ---------------- sin_t ----------------
	rfu_pkg::pipe_t pl_a;
	logic [rfu_pkg::SQ_STEPS-1:0] sin_t_a;

	rfu_sqrt u_sqrt_sin (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (vld_s6),
		.in_pl    (pl_s6),
		.in_rad   (rad_s6),
		.out_vld  (vld_a),
		.out_pl   (pl_a),
		.out_root (sin_t_a)
	);

	// ---------------- mid: sin_i, total reflection test ----------------
	rfu_pkg::pipe_t pl_m1, pl_m2, pl_m3;
	rfu_pkg::pipe_t plm2_c;
	logic [30:0] prod_m1;
	logic [19:0] si_c;
	logic [14:0] si_m2;
	logic [rfu_pkg::RAD_W-1:0] rad_m3;

	always_ff @(posedge clk) begin
		pl_m1   <= pl_a;
		prod_m1 <= sin_t_a * pl_a.q;
	end

	assign si_c = 20'((prod_m1 + 31'(rfu_pkg::HALF_Q)) >> rfu_pkg::QFRAC);

	always_comb begin
		plm2_c     = pl_m1;
		plm2_c.tir = (prod_m1 > 31'(rfu_pkg::TIR_LIM));
	end

	always_ff @(posedge clk) begin
		pl_m2 <= plm2_c;
		si_m2 <= (si_c > 20'(rfu_pkg::ONE)) ? 15'(rfu_pkg::ONE) : si_c[14:0];
	end

	always_ff @(posedge clk) begin
		pl_m3  <= pl_m2;
		rad_m3 <= rfu_pkg::RAD_W'(rfu_pkg::ONE_SQ)
			- rfu_pkg::RAD_W'(si_m2) * rfu_pkg::RAD_W'(si_m2);
	end

	// ---------------- cos_i ----------------
	rfu_pkg::pipe_t pl_c;
	logic [rfu_pkg::SQ_STEPS-1:0] cos_i_c;

	rfu_sqrt u_sqrt_cos (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (vld_m3),
		.in_pl    (pl_m3),
		.in_rad   (rad_m3),
		.out_vld  (vld_c),
		.out_pl   (pl_c),
		.out_root (cos_i_c)
	);

	// ---------------- back: direction and divider operands ----------------
	rfu_pkg::pipe_t pl_b1, pl_b2, pl_b3;
	rfu_pkg::pipe_t plb1_c;
	logic signed [32:0] nix_b1, niy_b1, niz_b1;
	logic [30:0] as_b1, ap_b1;

	always_comb begin
		plb1_c       = pl_c;
		plb1_c.cos_i = cos_i_c;
		plb1_c.om    = 15'(rfu_pkg::ONE) - cos_i_c;
	end

	always_ff @(posedge clk) begin
		pl_b1  <= plb1_c;
		nix_b1 <= pl_c.nx * $signed({1'b0, cos_i_c});
		niy_b1 <= pl_c.ny * $signed({1'b0, cos_i_c});
		niz_b1 <= pl_c.nz * $signed({1'b0, cos_i_c});
		as_b1  <= pl_c.q * cos_i_c;
		ap_b1  <= pl_c.q * pl_c.cos_t;
	end

	// b2: final direction, numerator/denominator pairs
	logic [30:0] bs_c, bp_c, qq_c, numa_c, dena_c, numb_c, denb_c;
	logic [rfu_pkg::DVS_W-1:0] numa_b2, dena_b2, numb_b2, denb_b2;
	rfu_pkg::pipe_t plb2_c;

	always_comb begin
		bs_c = 31'(pl_b1.cos_t) << rfu_pkg::QFRAC;
		bp_c = 31'(pl_b1.cos_i) << rfu_pkg::QFRAC;
		qq_c = 31'(pl_b1.q);
		if (pl_b1.mode) begin
			numa_c = (as_b1 > bs_c) ? (as_b1 - bs_c) : (bs_c - as_b1);
			dena_c = as_b1 + bs_c;
		end else begin
			// Schlick R0 from (1-q)/(1+q)
			numa_c = (qq_c > 31'(rfu_pkg::ONE_Q)) ? (qq_c - 31'(rfu_pkg::ONE_Q))
				: (31'(rfu_pkg::ONE_Q) - qq_c);
			dena_c = qq_c + 31'(rfu_pkg::ONE_Q);
		end
		numb_c = (ap_b1 > bp_c) ? (ap_b1 - bp_c) : (bp_c - ap_b1);
		denb_c = ap_b1 + bp_c;
		plb2_c    = pl_b1;
		plb2_c.rx = sat16(23'(rfu_pkg::rnd_s(48'(nix_b1), 5'(rfu_pkg::FRAC))) + 23'(pl_b1.ox));
		plb2_c.ry = sat16(23'(rfu_pkg::rnd_s(48'(niy_b1), 5'(rfu_pkg::FRAC))) + 23'(pl_b1.oy));
		plb2_c.rz = sat16(23'(rfu_pkg::rnd_s(48'(niz_b1), 5'(rfu_pkg::FRAC))) + 23'(pl_b1.oz));
	end

	always_ff @(posedge clk) begin
		pl_b2   <= plb2_c;
		numa_b2 <= numa_c;
		dena_b2 <= dena_c;
		numb_b2 <= numb_c;
		denb_b2 <= denb_c;
	end

	// b3: rounded dividends (num << FRAC) + den/2
	logic [rfu_pkg::DVD_W-1:0] dvda_b3, dvdb_b3;
	logic [rfu_pkg::DVS_W-1:0] dvsa_b3, dvsb_b3;
	rfu_pkg::pipe_t plb3_c;

	always_comb begin
		plb3_c        = pl_b2;
		plb3_c.zero_a = (dena_b2 == '0);
		plb3_c.zero_b = (denb_b2 == '0);
	end

	always_ff @(posedge clk) begin
		pl_b3   <= plb3_c;
		dvda_b3 <= (rfu_pkg::DVD_W'(numa_b2) << rfu_pkg::FRAC) + rfu_pkg::DVD_W'(dena_b2 >> 1);
		dvdb_b3 <= (rfu_pkg::DVD_W'(numb_b2) << rfu_pkg::FRAC) + rfu_pkg::DVD_W'(denb_b2 >> 1);
		dvsa_b3 <= dena_b2;
		dvsb_b3 <= denb_b2;
	end

	rfu_pkg::pipe_t pl_d;
	logic [rfu_pkg::DV_STEPS-1:0] qa_d, qb_d;

	rfu_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (vld_b3),
		.in_pl   (pl_b3),
		.dvd_a   (dvda_b3),
		.dvs_a   (dvsa_b3),
		.dvd_b   (dvdb_b3),
		.dvs_b   (dvsb_b3),
		.out_vld (vld_d),
		.out_pl  (pl_d),
		.quo_a   (qa_d),
		.quo_b   (qb_d)
	);

	// ---------------- finish: squares, (1-cos_i)^5, coefficient ----------
	rfu_pkg::pipe_t pl_f1, pl_f2, pl_f3, pl_f4, pl_f5;
	rfu_pkg::pipe_t plf2_c;
	logic [29:0] sqa_f1, sqb_f1, pw_f1, pw_f2, pw_f3, pw_f4, t_f5;
	logic [14:0] qa_eff, qb_eff;

	// zero denominator: ratio saturates to one
	assign qa_eff = pl_d.zero_a ? 15'(rfu_pkg::ONE) : qa_d;
	assign qb_eff = pl_d.zero_b ? 15'(rfu_pkg::ONE) : qb_d;

	always_ff @(posedge clk) begin
		pl_f1  <= pl_d;
		sqa_f1 <= qa_eff * qa_eff;
		sqb_f1 <= qb_eff * qb_eff;
		pw_f1  <= pl_d.om * pl_d.om;
	end

	always_comb begin
		plf2_c    = pl_f1;
		plf2_c.ra = 15'(rfu_pkg::rnd_u(32'(sqa_f1)));
		plf2_c.rb = 15'(rfu_pkg::rnd_u(32'(sqb_f1)));
	end

	always_ff @(posedge clk) begin
		pl_f2 <= plf2_c;
		pw_f2 <= 15'(rfu_pkg::rnd_u(32'(pw_f1))) * pl_f1.om;
	end

	always_ff @(posedge clk) begin
		pl_f3 <= pl_f2;
		pw_f3 <= 15'(rfu_pkg::rnd_u(32'(pw_f2))) * pl_f2.om;
	end

	always_ff @(posedge clk) begin
		pl_f4 <= pl_f3;
		pw_f4 <= 15'(rfu_pkg::rnd_u(32'(pw_f3))) * pl_f3.om;
	end

	// (1 - R0) * (1 - cos_i)^5
	always_ff @(posedge clk) begin
		pl_f5 <= pl_f4;
		t_f5  <= (15'(rfu_pkg::ONE) - pl_f4.ra) * 15'(rfu_pkg::rnd_u(32'(pw_f4)));
	end

	logic [16:0] coef_c;

	always_comb begin
		if (pl_f5.mode) begin
			coef_c = (17'(pl_f5.ra) + 17'(pl_f5.rb) + 17'd1) >> 1;
		end else begin
			coef_c = 17'(pl_f5.ra) + 17'(rfu_pkg::rnd_u(32'(t_f5)));
		end
		if (coef_c > 17'(rfu_pkg::ONE)) begin
			coef_c = 17'(rfu_pkg::ONE);
		end
	end

	// output register; total reflection overrides the computed values
	always_ff @(posedge clk) begin
		total_reflection <= pl_f5.tir;
		refracted_x      <= pl_f5.tir ? 16'sd0 : pl_f5.rx;
		refracted_y      <= pl_f5.tir ? 16'sd0 : pl_f5.ry;
		refracted_z      <= pl_f5.tir ? 16'sd0 : pl_f5.rz;
		reflect_coeff    <= pl_f5.tir ? 15'(rfu_pkg::ONE) : coef_c[14:0];
	end

endmodule
